[sv/csv_pkg.sv]
`default_nettype none

package csv_pkg;

  // Domain and counter sizes
  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned ADDR_BITS  = VALUE_BITS + 1;
  localparam int unsigned TREE_DEPTH = 1 << ADDR_BITS;
  localparam int unsigned LVL_BITS   = $clog2(VALUE_BITS + 1);
  localparam int unsigned WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [OUT_BITS-1:0]   out_t;

  // Operation codes carried by the op field
  typedef enum logic {
    OP_COUNT_INSERT = 1'b0,
    OP_CLEAR        = 1'b1
  } op_e;

  // Tree memory access: one write and two reads
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    count_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } mem_req_t;

  // Finished result offered by the sequencer
  typedef struct packed {
    logic valid;
    out_t count;
  } result_t;

  // Clamp a tree sum to the result field
  function automatic out_t out_sat(input count_t s);
    logic [WIDE_BITS-1:0] w;
    logic [WIDE_BITS-1:0] lim;
    w   = WIDE_BITS'(s);
    lim = WIDE_BITS'({OUT_BITS{1'b1}});
    if (w > lim) begin
      return {OUT_BITS{1'b1}};
    end
    return w[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/csv_mem.sv]
`default_nettype none

module csv_mem (
  input  wire logic              clk_i,
  input  wire csv_pkg::mem_req_t req_i,
  output csv_pkg::count_t        rd_a_o,
  output csv_pkg::count_t        rd_b_o
);

  csv_pkg::count_t mem_q [csv_pkg::TREE_DEPTH];
  csv_pkg::count_t rd_a_q;
  csv_pkg::count_t rd_b_q;

  // Write one entry, read two entries with registered data
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem_q[req_i.raddr_a];
    rd_b_q <= mem_q[req_i.raddr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

[sv/csv_alu.sv]
`default_nettype none

module csv_alu (
  input  wire csv_pkg::count_t cnt_i,
  input  wire csv_pkg::count_t acc_i,
  input  wire csv_pkg::count_t addend_i,
  output csv_pkg::count_t      inc_o,
  output csv_pkg::count_t      sum_o
);

  logic [csv_pkg::COUNT_BITS:0] wide_sum;

  // Saturating increment of a node count
  assign inc_o = (&cnt_i) ? cnt_i : cnt_i + csv_pkg::count_t'(1);

  // Saturating accumulate of a left-sibling count
  assign wide_sum = {1'b0, acc_i} + {1'b0, addend_i};
  assign sum_o    = wide_sum[csv_pkg::COUNT_BITS] ? '1 : wide_sum[csv_pkg::COUNT_BITS-1:0];

endmodule

`default_nettype wire

[sv/csv_ctrl.sv]
`default_nettype none

module csv_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              op_i,
  input  wire csv_pkg::value_t   value_i,
  output logic                   in_stall_o,
  input  wire csv_pkg::count_t   rd_a_i,
  input  wire csv_pkg::count_t   rd_b_i,
  output csv_pkg::mem_req_t      req_o,
  output csv_pkg::result_t       res_o,
  input  wire logic              res_take_i
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  csv_pkg::addr_t            sweep_q, sweep_d;
  csv_pkg::addr_t            node_q, node_d;
  csv_pkg::value_t           val_q, val_d;
  logic [csv_pkg::LVL_BITS-1:0] cnt_q, cnt_d;
  logic                      add_q, add_d;
  logic                      pend_q, pend_d;
  csv_pkg::count_t           sum_q, sum_d;

  csv_pkg::count_t           inc;
  csv_pkg::count_t           acc_sum;
  logic                      bit_v;
  csv_pkg::addr_t            child;
  csv_pkg::addr_t            sibling;

  // Shared increment and accumulate unit
  csv_alu u_alu (
    .cnt_i    (rd_a_i),
    .acc_i    (sum_q),
    .addend_i (rd_b_i),
    .inc_o    (inc),
    .sum_o    (acc_sum)
  );

  // Descend one level: path child and its left sibling
  assign bit_v   = val_q[csv_pkg::VALUE_BITS-1];
  assign child   = {node_q[csv_pkg::ADDR_BITS-2:0], bit_v};
  assign sibling = {node_q[csv_pkg::ADDR_BITS-2:0], 1'b0};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.count = csv_pkg::out_sat(sum_q);

  // Sequence the sweep and the level walk
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    node_d  = node_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    add_d   = add_q;
    pend_d  = pend_q;
    sum_d   = sum_q;
    req_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.waddr = sweep_q;
        req_o.wdata = '0;
        sweep_d     = sweep_q + csv_pkg::addr_t'(1);
        if (&sweep_q) begin
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == csv_pkg::OP_CLEAR) begin
            state_d = ST_CLEAR;
            sweep_d = '0;
            pend_d  = 1'b1;
            sum_d   = '0;
          end else begin
            state_d       = ST_WALK;
            node_d        = csv_pkg::addr_t'(1);
            req_o.raddr_a = csv_pkg::addr_t'(1);
            val_d         = value_i;
            cnt_d         = csv_pkg::LVL_BITS'(csv_pkg::VALUE_BITS);
            add_d         = 1'b0;
            pend_d        = 1'b1;
            sum_d         = '0;
          end
        end
      end
      ST_WALK: begin
        // Write back the node read last cycle, fold in its sibling
        req_o.we    = 1'b1;
        req_o.waddr = node_q;
        req_o.wdata = inc;
        if (add_q) begin
          sum_d = acc_sum;
        end
        if (cnt_q != '0) begin
          req_o.raddr_a = child;
          req_o.raddr_b = sibling;
          node_d        = child;
          add_d         = bit_v;
          val_d         = val_q << 1;
          cnt_d         = cnt_q - csv_pkg::LVL_BITS'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state: clearing pass runs straight after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      add_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      add_q   <= add_d;
    end
  end

  // Walk payload
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    val_q  <= val_d;
    sum_q  <= sum_d;
  end

endmodule

`default_nettype wire

[sv/count_smaller_seen_values.sv]
`default_nettype none

// Counts, for each value, how many earlier-inserted values are strictly smaller, then
// inserts it into a segment tree of saturating occurrence counts held in one on-chip
// memory (2^(VALUE_BITS+1) entries). A count-and-insert transaction walks the tree one
// level at a time, using the single write port to increment the path node while the
// next level's node and left sibling are read. A clear transaction sweeps the memory one
// entry per cycle. After reset the same sweep runs with in_stall_o high. The result sits
// in an output register, so the next transaction is taken while it waits to be consumed.
module count_smaller_seen_values (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   op_i,
  input  wire csv_pkg::value_t        value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output csv_pkg::out_t               smaller_count_o
);

  csv_pkg::mem_req_t mem_req;
  csv_pkg::count_t   rd_a;
  csv_pkg::count_t   rd_b;
  csv_pkg::result_t  res;
  logic              res_take;
  logic              out_valid_q;
  csv_pkg::out_t     out_count_q;

  csv_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  csv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .value_i    (value_i),
    .in_stall_o (in_stall_o),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .req_o      (mem_req),
    .res_o      (res),
    .res_take_i (res_take)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_count_q <= res.count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign smaller_count_o = out_count_q;

  // A counting tree write (nonzero data) never lands on an entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.wdata != '0) |->
      (mem_req.waddr != mem_req.raddr_a && mem_req.waddr != mem_req.raddr_b))
    else $error("tree write collides with a read address");

  // Hold a finished result until the output register takes it
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res_take) |=> (res.valid && $stable(res.count)))
    else $error("finished result dropped or changed before it was taken");

  // An accepted transaction keeps the block busy and has no result yet
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !res.valid))
    else $error("block free or result offered right after accepting a transaction");

endmodule

`default_nettype wire
